[hdl/tnc_pkg.sv]
// Shared constants and types for the markup tag nesting checker.
`default_nettype none

package tnc_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_MAX_NAME    = 23;

  localparam logic [7:0]  BYTE_LT    = 8'h3C;
  localparam logic [7:0]  BYTE_GT    = 8'h3E;
  localparam logic [7:0]  BYTE_SLASH = 8'h2F;
  localparam logic [7:0]  BYTE_NL    = 8'h0A;
  localparam logic [15:0] PAIR_BR    = 16'h6272;
  localparam logic [15:0] PAIR_HR    = 16'h6872;

  typedef struct packed {
    logic chars;
    logic len;
  } tnc_wr_en_t;

endpackage

`default_nettype wire

[hdl/tnc_byte_if.sv]
// Text byte channel: valid, ready and one raw character.
`default_nettype none

interface tnc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

[hdl/tnc_verdict_if.sv]
// Verdict channel: valid, ready and the nesting verdict bit.
`default_nettype none

interface tnc_verdict_if;
  logic valid;
  logic ready;
  logic verdict_wrong;

  modport source (output valid, output verdict_wrong, input ready);
  modport sink (input valid, input verdict_wrong, output ready);
endinterface

`default_nettype wire

[hdl/tnc_name_store.sv]
// Name store: stacked name bytes and name lengths, registered reads.
`default_nettype none

module tnc_name_store
  import tnc_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_NAME    = DEF_MAX_NAME,
  localparam int CHARS      = STACK_DEPTH * MAX_NAME,
  localparam int CAW        = $clog2(CHARS),
  localparam int SIW        = $clog2(STACK_DEPTH),
  localparam int LW         = $clog2(MAX_NAME + 1)
) (
  input  wire logic             clk,
  input  wire tnc_wr_en_t       wr_en,
  input  wire logic [CAW-1:0]   char_waddr,
  input  wire logic [7:0]       char_wdata,
  input  wire logic [CAW-1:0]   char_raddr,
  output      logic [7:0]       char_rdata,
  input  wire logic [SIW-1:0]   len_waddr,
  input  wire logic [LW-1:0]    len_wdata,
  input  wire logic [SIW-1:0]   len_raddr,
  output      logic [LW-1:0]    len_rdata
);

  logic [7:0]    name_chars [CHARS];
  logic [LW-1:0] name_lengths [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.chars) begin
      name_chars[char_waddr] <= char_wdata;
    end
    char_rdata <= name_chars[char_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_en.len) begin
      name_lengths[len_waddr] <= len_wdata;
    end
    len_rdata <= name_lengths[len_raddr];
  end

endmodule

`default_nettype wire

[hdl/tnc_parser.sv]
// Tag parser: input register, nesting state, store addressing, verdict register.
`default_nettype none

module tnc_parser
  import tnc_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_NAME    = DEF_MAX_NAME,
  localparam int CAW        = $clog2(STACK_DEPTH * MAX_NAME),
  localparam int SIW        = $clog2(STACK_DEPTH),
  localparam int LW         = $clog2(MAX_NAME + 1),
  localparam int PW         = $clog2(MAX_NAME + 2),
  localparam int DW         = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  tnc_byte_if.sink            text,
  tnc_verdict_if.source       verdict,
  output      tnc_wr_en_t     wr_en,
  output      logic [CAW-1:0] char_waddr,
  output      logic [7:0]     char_wdata,
  output      logic [CAW-1:0] char_raddr,
  input  wire logic [7:0]     char_rdata,
  output      logic [SIW-1:0] len_waddr,
  output      logic [LW-1:0]  len_wdata,
  output      logic [SIW-1:0] len_raddr,
  input  wire logic [LW-1:0]  len_rdata
);

  logic          stage_valid;
  logic [7:0]    stage_byte;
  logic          out_valid;
  logic          out_wrong;

  logic          inside_tag, inside_tag_next;
  logic          closing_tag, closing_tag_next;
  logic [PW-1:0] name_position, name_position_next;
  logic [15:0]   first_two_chars, first_two_chars_next;
  logic          still_matching, still_matching_next;
  logic [DW-1:0] stack_depth, stack_depth_next;
  logic          error_seen, error_seen_next;

  logic          is_nl;
  logic          out_free;
  logic          fire;
  logic          stack_full;
  logic          wrong;
  logic [SIW-1:0] top_next;
  logic [PW-1:0]  pos_read;

  assign is_nl      = (stage_byte == BYTE_NL);
  assign out_free   = !out_valid || verdict.ready;
  assign fire       = stage_valid && (!is_nl || out_free);
  assign text.ready = !stage_valid || fire;
  assign stack_full = (stack_depth == DW'(STACK_DEPTH));
  assign wrong      = inside_tag || error_seen || (stack_depth != '0);

  assign verdict.valid         = out_valid;
  assign verdict.verdict_wrong = out_wrong;

  always_comb begin
    inside_tag_next      = inside_tag;
    closing_tag_next     = closing_tag;
    name_position_next   = name_position;
    first_two_chars_next = first_two_chars;
    still_matching_next  = still_matching;
    stack_depth_next     = stack_depth;
    error_seen_next      = error_seen;
    wr_en                = '0;

    if (fire) begin
      if (is_nl) begin
        inside_tag_next      = 1'b0;
        closing_tag_next     = 1'b0;
        name_position_next   = '0;
        first_two_chars_next = '0;
        still_matching_next  = 1'b1;
        stack_depth_next     = '0;
        error_seen_next      = 1'b0;
      end else if (!inside_tag) begin
        if (stage_byte == BYTE_LT) begin
          inside_tag_next      = 1'b1;
          closing_tag_next     = 1'b0;
          name_position_next   = '0;
          first_two_chars_next = '0;
          still_matching_next  = 1'b1;
        end
      end else if (stage_byte == BYTE_GT) begin
        inside_tag_next = 1'b0;
        if (name_position <= PW'(MAX_NAME)) begin
          if (!closing_tag) begin
            if (name_position == PW'(2) &&
                (first_two_chars == PAIR_BR || first_two_chars == PAIR_HR)) begin
              stack_depth_next = stack_depth;
            end else if (stack_full) begin
              error_seen_next = 1'b1;
            end else begin
              wr_en.len        = 1'b1;
              stack_depth_next = stack_depth + DW'(1);
            end
          end else begin
            if (stack_depth == '0) begin
              error_seen_next = 1'b1;
            end else if (still_matching && name_position == PW'(len_rdata)) begin
              stack_depth_next = stack_depth - DW'(1);
            end
          end
        end
      end else if (!closing_tag && name_position == '0 && stage_byte == BYTE_SLASH) begin
        closing_tag_next = 1'b1;
      end else if (name_position >= PW'(MAX_NAME)) begin
        error_seen_next    = 1'b1;
        name_position_next = PW'(MAX_NAME + 1);
      end else begin
        if (!closing_tag) begin
          wr_en.chars = !stack_full;
          if (name_position < PW'(2)) begin
            first_two_chars_next = {first_two_chars[7:0], stage_byte};
          end
        end else if (stack_depth == '0) begin
          still_matching_next = 1'b0;
        end else if (name_position >= PW'(len_rdata) || char_rdata != stage_byte) begin
          still_matching_next = 1'b0;
        end
        name_position_next = name_position + PW'(1);
      end
    end
  end

  assign char_waddr = CAW'(int'(stack_depth[SIW-1:0]) * MAX_NAME + int'(name_position));
  assign char_wdata = stage_byte;
  assign len_waddr  = stack_depth[SIW-1:0];
  assign len_wdata  = LW'(name_position);

  assign top_next   = (stack_depth_next == '0) ? '0 : SIW'(stack_depth_next - DW'(1));
  assign pos_read   = (name_position_next < PW'(MAX_NAME)) ? name_position_next : '0;
  assign len_raddr  = top_next;
  assign char_raddr = CAW'(int'(top_next) * MAX_NAME + int'(pos_read));

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid     <= 1'b0;
      out_valid       <= 1'b0;
      inside_tag      <= 1'b0;
      closing_tag     <= 1'b0;
      name_position   <= '0;
      first_two_chars <= '0;
      still_matching  <= 1'b1;
      stack_depth     <= '0;
      error_seen      <= 1'b0;
    end else begin
      if (text.valid && text.ready) begin
        stage_valid <= 1'b1;
      end else if (fire) begin
        stage_valid <= 1'b0;
      end
      if (fire && is_nl) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
      inside_tag      <= inside_tag_next;
      closing_tag     <= closing_tag_next;
      name_position   <= name_position_next;
      first_two_chars <= first_two_chars_next;
      still_matching  <= still_matching_next;
      stack_depth     <= stack_depth_next;
      error_seen      <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      stage_byte <= text.text_byte;
    end
    if (fire && is_nl) begin
      out_wrong <= wrong;
    end
  end

  a_nl_clears: assert property (@(posedge clk) disable iff (rst)
    fire && is_nl |=> stack_depth == '0 && !error_seen && !inside_tag)
    else $error("state not cleared after newline");

  a_depth_step: assert property (@(posedge clk) disable iff (rst)
    !(fire && is_nl) |=> stack_depth == $past(stack_depth) ||
                         stack_depth == $past(stack_depth) + DW'(1) ||
                         stack_depth == $past(stack_depth) - DW'(1))
    else $error("stack depth moved by more than one");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    wr_en.len |-> !stack_full && stack_depth_next == stack_depth + DW'(1))
    else $error("length write without push");

  a_verdict_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire && is_nl))
    else $error("verdict without newline");

endmodule

`default_nettype wire

[hdl/markup_tag_nesting_checker_unit.sv]
// Markup tag nesting checker: one text byte per cycle in, one verdict per line out.
// Accepts one text byte every clock cycle, sustained, with or without stalls on the
// verdict side beyond a pending newline. A byte passes an input register, then the
// parser updates the tag state and the name stack; a newline's verdict is
// registered in the output register once the newline is parsed. The rate is
// set by the name store: each byte needs one byte read, prefetched from the parse
// state of the previous byte, and at most one write. The store holds
// STACK_DEPTH * MAX_NAME name bytes and STACK_DEPTH lengths, needs no clearing
// after reset, and the block is ready right out of reset.
`default_nettype none

module markup_tag_nesting_checker_unit
  import tnc_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_NAME    = DEF_MAX_NAME,
  localparam int CAW        = $clog2(STACK_DEPTH * MAX_NAME),
  localparam int SIW        = $clog2(STACK_DEPTH),
  localparam int LW         = $clog2(MAX_NAME + 1)
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tnc_byte_if.sink      text,
  tnc_verdict_if.source verdict
);

  tnc_wr_en_t     wr_en;
  logic [CAW-1:0] char_waddr;
  logic [7:0]     char_wdata;
  logic [CAW-1:0] char_raddr;
  logic [7:0]     char_rdata;
  logic [SIW-1:0] len_waddr;
  logic [LW-1:0]  len_wdata;
  logic [SIW-1:0] len_raddr;
  logic [LW-1:0]  len_rdata;

  tnc_parser #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_NAME    (MAX_NAME)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .verdict    (verdict),
    .wr_en      (wr_en),
    .char_waddr (char_waddr),
    .char_wdata (char_wdata),
    .char_raddr (char_raddr),
    .char_rdata (char_rdata),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata)
  );

  tnc_name_store #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_NAME    (MAX_NAME)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .char_waddr (char_waddr),
    .char_wdata (char_wdata),
    .char_raddr (char_raddr),
    .char_rdata (char_rdata),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata)
  );

endmodule

`default_nettype wire
